### rtl/rational_fraction_alu_assert.svh
// ----------------------------------------------------------------------------
// rational fraction alu assertion macros
// Shared assertion shorthands, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_FRACTION_ALU_ASSERT_SVH
`define RATIONAL_FRACTION_ALU_ASSERT_SVH

// plain property check on the block clock
`define RFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RFA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Operation and status codes and the control word that travels down the pipe.
// ----------------------------------------------------------------------------
package rfa_pkg;

  // operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // per-stage control word
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    neg;
    logic    zero;
  } ctl_t;

endpackage

### rtl/rational_fraction_alu.sv
// Rational fraction ALU: a op b for fractions a_num/a_den and b_num/b_den,
// op from mode_i (add, subtract, multiply, divide), result in lowest terms
// with the sign on the numerator and a zero result shown as 0/1.
// Input channel valid_i/stall_o, result channel valid_o/stall_i; an item
// moves when valid is high and stall is low.
// The pipeline is three front stages, 4*OPERAND_WIDTH+1 binary gcd steps,
// one shift stage, 2*OPERAND_WIDTH restoring divide steps and the output
// register.
// Throughput is one item per cycle while no result is held by a stall; each
// gcd step and each quotient bit has its own stage, so no step is iterated.
// A zero input denominator gives status 1, division by a zero fraction
// status 2, both with 0/0.
// Reset clears all valid bits; no clearing pass is needed.
// When the receiver stalls a waiting result, the whole pipe holds and
// stall_o is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Top level: front products, gcd step chain, scaling and divide chain.
// ----------------------------------------------------------------------------
module rational_fraction_alu #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [1:0]                       mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]  a_num_i,
  input  logic [OPERAND_WIDTH-2:0]         a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]  b_num_i,
  input  logic [OPERAND_WIDTH-2:0]         b_den_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [31:0]               res_num_o,
  output logic [30:0]                      res_den_o,
  output logic [1:0]                       status_o
);
  import rfa_pkg::*;

  localparam int MW   = 2 * OPERAND_WIDTH;
  localparam int KW   = $clog2(MW + 1);
  localparam int NGCD = 2 * MW + 1;

  logic adv;

  // pipe advance: hold everything while a result waits on a stall
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // front stages
  ctl_t          f_ctl;
  logic [MW-1:0] f_mag, f_den;

  rfa_front #(.W(OPERAND_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_i),
    .mode_i  (mode_i),
    .a_num_i (a_num_i),
    .a_den_i (a_den_i),
    .b_num_i (b_num_i),
    .b_den_i (b_den_i),
    .ctl_o   (f_ctl),
    .mag_o   (f_mag),
    .den_o   (f_den)
  );

  // gcd step chain
  ctl_t          g_ctl [NGCD+1];
  logic [MW-1:0] g_u [NGCD+1];
  logic [MW-1:0] g_v [NGCD+1];
  logic [KW-1:0] g_k [NGCD+1];
  logic [MW-1:0] g_n [NGCD+1];
  logic [MW-1:0] g_d [NGCD+1];

  assign g_ctl[0] = f_ctl;
  assign g_u[0]   = f_mag;
  assign g_v[0]   = f_den;
  assign g_k[0]   = '0;
  assign g_n[0]   = f_mag;
  assign g_d[0]   = f_den;

  for (genvar i = 0; i < NGCD; i++) begin : g_gcd
    rfa_gcd_stage #(.MW(MW), .KW(KW)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (g_ctl[i]),
      .u_i    (g_u[i]),
      .v_i    (g_v[i]),
      .k_i    (g_k[i]),
      .n_i    (g_n[i]),
      .d_i    (g_d[i]),
      .ctl_o  (g_ctl[i+1]),
      .u_o    (g_u[i+1]),
      .v_o    (g_v[i+1]),
      .k_o    (g_k[i+1]),
      .n_o    (g_n[i+1]),
      .d_o    (g_d[i+1])
    );
  end

  // scaling stage: strip the common power of two, odd part is the divisor
  ctl_t          sh_ctl_q;
  logic [MW-1:0] sh_dv_q, sh_n_q, sh_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_ctl_q <= '0;
    end else if (adv) begin
      sh_ctl_q <= g_ctl[NGCD];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_dv_q <= g_u[NGCD] | g_v[NGCD];
      sh_n_q  <= g_n[NGCD] >> g_k[NGCD];
      sh_d_q  <= g_d[NGCD] >> g_k[NGCD];
    end
  end

  // divide chain, numerator and denominator side by side
  ctl_t          d_ctl [MW+1];
  logic [MW-1:0] d_dv [MW+1];
  logic [MW-1:0] d_r1 [MW+1];
  logic [MW-1:0] d_q1 [MW+1];
  logic [MW-1:0] d_r2 [MW+1];
  logic [MW-1:0] d_q2 [MW+1];

  assign d_ctl[0] = sh_ctl_q;
  assign d_dv[0]  = sh_dv_q;
  assign d_r1[0]  = '0;
  assign d_q1[0]  = sh_n_q;
  assign d_r2[0]  = '0;
  assign d_q2[0]  = sh_d_q;

  for (genvar j = 0; j < MW; j++) begin : g_div
    rfa_div_stage #(.MW(MW)) u_bit (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (d_ctl[j]),
      .dv_i   (d_dv[j]),
      .r1_i   (d_r1[j]),
      .q1_i   (d_q1[j]),
      .r2_i   (d_r2[j]),
      .q2_i   (d_q2[j]),
      .ctl_o  (d_ctl[j+1]),
      .dv_o   (d_dv[j+1]),
      .r1_o   (d_r1[j+1]),
      .q1_o   (d_q1[j+1]),
      .r2_o   (d_r2[j+1]),
      .q2_o   (d_q2[j+1])
    );
  end

  // result formatting
  logic [MW-1:0]  snum;
  logic [31:0]    num_ext;
  logic [30:0]    den_ext;
  logic [31:0]    res_num_d;
  logic [30:0]    res_den_d;
  ctl_t           fin_ctl;

  assign fin_ctl = d_ctl[MW];
  assign snum    = fin_ctl.neg ? -d_q1[MW] : d_q1[MW];

  if (MW >= 32) begin : g_num_cut
    assign num_ext = snum[31:0];
  end else begin : g_num_ext
    assign num_ext = {{(32-MW){snum[MW-1]}}, snum};
  end

  if (MW >= 31) begin : g_den_cut
    assign den_ext = d_q2[MW][30:0];
  end else begin : g_den_ext
    assign den_ext = {{(31-MW){1'b0}}, d_q2[MW]};
  end

  always_comb begin
    if (fin_ctl.status != ST_OK) begin
      res_num_d = '0;
      res_den_d = '0;
    end else if (fin_ctl.zero) begin
      res_num_d = '0;
      res_den_d = 31'd1;
    end else begin
      res_num_d = num_ext;
      res_den_d = den_ext;
    end
  end

  // output register
  logic           out_valid_q;
  logic [31:0]    res_num_q;
  logic [30:0]    res_den_q;
  logic [1:0]     status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_num_q <= res_num_d;
      res_den_q <= res_den_d;
      status_q  <= fin_ctl.status;
    end
  end

  assign valid_o   = out_valid_q;
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule

### rtl/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front
// Cross products, numerator by mode, and sign/magnitude split: three stages.
// ----------------------------------------------------------------------------
module rfa_front #(
  parameter int W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [1:0]           mode_i,
  input  logic signed [W-1:0]  a_num_i,
  input  logic [W-2:0]         a_den_i,
  input  logic signed [W-1:0]  b_num_i,
  input  logic [W-2:0]         b_den_i,
  output rfa_pkg::ctl_t        ctl_o,
  output logic [2*W-1:0]       mag_o,
  output logic [2*W-1:0]       den_o
);
  import rfa_pkg::*;

  localparam int PW = 2 * W + 2;

  logic signed [W:0]    an_ext, bn_ext, ad_s, bd_s, bn_abs, dsel;
  logic signed [PW-1:0] m1_d, m2_d, mn_d, md_d;
  logic signed [PW-1:0] m1_q, m2_q, mn_q, md_q;
  logic [1:0]           mode_q;
  logic                 bneg_q;
  ctl_t                 ctl_a_d, ctl_a_q, ctl_b_q, ctl_c_d, ctl_c_q;
  logic signed [PW-1:0] sum_d, sum_q, mag_full;
  logic [2*W-1:0]       den_b_q, mag_q, den_c_q;

  // stage a: products and status
  always_comb begin
    an_ext = {a_num_i[W-1], a_num_i};
    bn_ext = {b_num_i[W-1], b_num_i};
    ad_s   = {2'b00, a_den_i};
    bd_s   = {2'b00, b_den_i};
    bn_abs = bn_ext[W] ? -bn_ext : bn_ext;
    dsel   = (mode_i == MODE_DIV) ? bn_abs : bd_s;
    m1_d   = PW'(an_ext) * PW'(bd_s);
    m2_d   = PW'(bn_ext) * PW'(ad_s);
    mn_d   = PW'(an_ext) * PW'(bn_ext);
    md_d   = PW'(ad_s) * PW'(dsel);
    ctl_a_d = '0;
    ctl_a_d.valid = valid_i;
    if (a_den_i == '0 || b_den_i == '0) begin
      ctl_a_d.status = ST_ZERO_DEN;
    end else if (mode_i == MODE_DIV && b_num_i == '0) begin
      ctl_a_d.status = ST_DIV_ZERO;
    end else begin
      ctl_a_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (adv_i) begin
      ctl_a_q <= ctl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      mn_q   <= mn_d;
      md_q   <= md_d;
      mode_q <= mode_i;
      bneg_q <= b_num_i[W-1];
    end
  end

  // stage b: combine numerator
  always_comb begin
    case (mode_q)
      MODE_ADD: sum_d = m1_q + m2_q;
      MODE_SUB: sum_d = m1_q - m2_q;
      MODE_MUL: sum_d = mn_q;
      MODE_DIV: sum_d = bneg_q ? -m1_q : m1_q;
      default:  sum_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (adv_i) begin
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q   <= sum_d;
      den_b_q <= md_q[2*W-1:0];
    end
  end

  // stage c: sign and magnitude
  always_comb begin
    mag_full     = sum_q[PW-1] ? -sum_q : sum_q;
    ctl_c_d      = ctl_b_q;
    ctl_c_d.neg  = sum_q[PW-1];
    ctl_c_d.zero = (sum_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
    end else if (adv_i) begin
      ctl_c_q <= ctl_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_q   <= mag_full[2*W-1:0];
      den_c_q <= den_b_q;
    end
  end

  assign ctl_o = ctl_c_q;
  assign mag_o = mag_q;
  assign den_o = den_c_q;

endmodule

### rtl/rfa_gcd_stage.sv
// ----------------------------------------------------------------------------
// rfa_gcd_stage
// One registered step of the binary gcd, carrying the original operands.
// ----------------------------------------------------------------------------
module rfa_gcd_stage #(
  parameter int MW = 32,
  parameter int KW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  rfa_pkg::ctl_t ctl_i,
  input  logic [MW-1:0] u_i,
  input  logic [MW-1:0] v_i,
  input  logic [KW-1:0] k_i,
  input  logic [MW-1:0] n_i,
  input  logic [MW-1:0] d_i,
  output rfa_pkg::ctl_t ctl_o,
  output logic [MW-1:0] u_o,
  output logic [MW-1:0] v_o,
  output logic [KW-1:0] k_o,
  output logic [MW-1:0] n_o,
  output logic [MW-1:0] d_o
);
  import rfa_pkg::*;

  ctl_t          ctl_q;
  logic [MW-1:0] u_d, v_d, u_q, v_q, n_q, d_q, diff_uv, diff_vu;
  logic [KW-1:0] k_d, k_q;

  // one stein step; holds once either side reaches zero
  always_comb begin
    diff_uv = u_i - v_i;
    diff_vu = v_i - u_i;
    u_d = u_i;
    v_d = v_i;
    k_d = k_i;
    if (u_i == '0 || v_i == '0) begin
      u_d = u_i;
    end else if (!u_i[0] && !v_i[0]) begin
      u_d = u_i >> 1;
      v_d = v_i >> 1;
      k_d = k_i + {{(KW-1){1'b0}}, 1'b1};
    end else if (!u_i[0]) begin
      u_d = u_i >> 1;
    end else if (!v_i[0]) begin
      v_d = v_i >> 1;
    end else if (u_i >= v_i) begin
      u_d = diff_uv >> 1;
    end else begin
      v_d = diff_vu >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      u_q <= u_d;
      v_q <= v_d;
      k_q <= k_d;
      n_q <= n_i;
      d_q <= d_i;
    end
  end

  assign ctl_o = ctl_q;
  assign u_o   = u_q;
  assign v_o   = v_q;
  assign k_o   = k_q;
  assign n_o   = n_q;
  assign d_o   = d_q;

endmodule

### rtl/rfa_div_stage.sv
// ----------------------------------------------------------------------------
// rfa_div_stage
// One registered quotient bit of restoring division, two lanes, one divisor.
// ----------------------------------------------------------------------------
module rfa_div_stage #(
  parameter int MW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  rfa_pkg::ctl_t ctl_i,
  input  logic [MW-1:0] dv_i,
  input  logic [MW-1:0] r1_i,
  input  logic [MW-1:0] q1_i,
  input  logic [MW-1:0] r2_i,
  input  logic [MW-1:0] q2_i,
  output rfa_pkg::ctl_t ctl_o,
  output logic [MW-1:0] dv_o,
  output logic [MW-1:0] r1_o,
  output logic [MW-1:0] q1_o,
  output logic [MW-1:0] r2_o,
  output logic [MW-1:0] q2_o
);
  import rfa_pkg::*;

  ctl_t          ctl_q;
  logic [MW:0]   t1, t2, s1, s2;
  logic          ge1, ge2;
  logic [MW-1:0] dv_q, r1_q, q1_q, r2_q, q2_q;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    t1  = {r1_i, q1_i[MW-1]};
    t2  = {r2_i, q2_i[MW-1]};
    s1  = t1 - {1'b0, dv_i};
    s2  = t2 - {1'b0, dv_i};
    ge1 = (t1 >= {1'b0, dv_i});
    ge2 = (t2 >= {1'b0, dv_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_q <= dv_i;
      r1_q <= ge1 ? s1[MW-1:0] : t1[MW-1:0];
      r2_q <= ge2 ? s2[MW-1:0] : t2[MW-1:0];
      q1_q <= {q1_i[MW-2:0], ge1};
      q2_q <= {q2_i[MW-2:0], ge2};
    end
  end

  assign ctl_o = ctl_q;
  assign dv_o  = dv_q;
  assign r1_o  = r1_q;
  assign q1_o  = q1_q;
  assign r2_o  = r2_q;
  assign q2_o  = q2_q;

endmodule

### rtl/rational_fraction_alu_chk.sv
// ----------------------------------------------------------------------------
// rational_fraction_alu_chk
// Port-level checks of the result and input channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "rational_fraction_alu_assert.svh"

module rational_fraction_alu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] res_num_o,
  input logic [30:0] res_den_o,
  input logic [1:0]  status_o
);
  import rfa_pkg::*;

  // a stalled result item holds its numerator
  `RFA_ASSERT_NXT(a_hold, valid_o && stall_i, valid_o && $stable(res_num_o), "result item dropped under stall")

  // error items carry 0/0
  `RFA_ASSERT_IMP(a_err_zero, valid_o && status_o != ST_OK, res_num_o == 0 && res_den_o == 0, "error item not 0/0")

  // good items never have a zero denominator
  `RFA_ASSERT_IMP(a_den_pos, valid_o && status_o == ST_OK, res_den_o != 0, "zero denominator on good item")

  // input side only stalls when a result is held back
  `RFA_ASSERT(a_no_idle_stall, !(stall_o && !(valid_o && stall_i)), "input stalled without cause")

endmodule

bind rational_fraction_alu rational_fraction_alu_chk u_chk (.*);
